### hw/rtl/cfd_pkg.sv
package cfd_pkg;

   localparam int FRAME_BITS = 23;
   localparam int MAG_BITS   = 20;

   localparam int SYNC_W    = 16;
   localparam int IDLE_W    = 24;
   localparam int VAL_W     = 21;
   localparam int BIT_IDX_W = $clog2(FRAME_BITS + 1);
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 32;

   localparam logic [SYNC_W-1:0] LOW_MAX  = {SYNC_W{1'b1}};
   localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

   localparam logic [SYNC_W-1:0] SYNC_GAP_RESET = SYNC_W'(500);
   localparam logic [IDLE_W-1:0] TIMEOUT_RESET  = IDLE_W'(100000);

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = CSR_IDX_W'(1);

   typedef struct packed {
      logic clk_level;
      logic data_level;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] measured_value;
      logic                    frame_done;
      logic                    value_changed;
      logic                    gauge_attached;
   } rsp_type;

   typedef struct packed {
      logic [SYNC_W-1:0] sync_gap_ticks;
      logic [IDLE_W-1:0] timeout_ticks;
   } cfg_type;

endpackage

### hw/rtl/cfd_csr.sv
module cfd_csr
   import cfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_GAP: cfg_in.sync_gap_ticks = csr_data[SYNC_W-1:0];
            CSR_TIMEOUT:  cfg_in.timeout_ticks  = csr_data[IDLE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_gap_ticks <= SYNC_GAP_RESET;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/cfd_decode.sv
module cfd_decode
   import cfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic                 prev_clk_ff, prev_clk_in;
   logic                 in_frame_ff, in_frame_in;
   logic [SYNC_W-1:0]    low_time_ff, low_time_in;
   logic [IDLE_W-1:0]    idle_time_ff, idle_time_in;
   logic [BIT_IDX_W-1:0] bit_index_ff, bit_index_in;
   logic                 saw_high_ff, saw_high_in;
   logic [MAG_BITS-1:0]  shift_ff, shift_in;
   logic                 sign_ff, sign_in;
   logic [VAL_W-1:0]     stored_ff, stored_in;
   logic                 attached_ff, attached_in;

   logic                 bit_val;
   logic [BIT_IDX_W-1:0] bit_next;
   logic [VAL_W-1:0]     mag_ext;
   logic [VAL_W-1:0]     value;
   logic                 done;
   logic                 changed;

   always_comb begin
      prev_clk_in  = req.clk_level;
      in_frame_in  = in_frame_ff;
      low_time_in  = low_time_ff;
      idle_time_in = idle_time_ff;
      bit_index_in = bit_index_ff;
      saw_high_in  = saw_high_ff;
      shift_in     = shift_ff;
      sign_in      = sign_ff;
      stored_in    = stored_ff;
      attached_in  = attached_ff;
      bit_val      = ~saw_high_ff;
      bit_next     = bit_index_ff + BIT_IDX_W'(1);
      mag_ext      = '0;
      value        = '0;
      done         = 1'b0;
      changed      = 1'b0;

      if (req.clk_level != prev_clk_ff) begin
         idle_time_in = '0;
      end else begin
         if (idle_time_ff != IDLE_MAX) begin
            idle_time_in = idle_time_ff + IDLE_W'(1);
         end
         if (idle_time_in > cfg.timeout_ticks) begin
            in_frame_in = 1'b0;
            attached_in = 1'b0;
         end
      end

      if (!req.clk_level) begin
         if (prev_clk_ff) begin
            saw_high_in = req.data_level;
            low_time_in = SYNC_W'(1);
         end else begin
            saw_high_in = saw_high_ff | req.data_level;
            if (low_time_ff != LOW_MAX) begin
               low_time_in = low_time_ff + SYNC_W'(1);
            end
         end
      end else begin
         if (!prev_clk_ff) begin
            if (in_frame_ff) begin
               for (int i = 0; i < MAG_BITS; i++) begin
                  if (bit_val && bit_index_ff == BIT_IDX_W'(i)) begin
                     shift_in[i] = 1'b1;
                  end
               end
               if (bit_index_ff == BIT_IDX_W'(MAG_BITS)) begin
                  sign_in = bit_val;
               end
               bit_index_in = bit_next;
               if (bit_next >= BIT_IDX_W'(FRAME_BITS)) begin
                  mag_ext      = VAL_W'(shift_in);
                  value        = sign_in ? (VAL_W'(0) - mag_ext) : mag_ext;
                  changed      = (value != stored_ff);
                  stored_in    = value;
                  attached_in  = 1'b1;
                  done         = 1'b1;
                  in_frame_in  = 1'b0;
                  bit_index_in = '0;
               end
            end else if (low_time_ff > cfg.sync_gap_ticks) begin
               in_frame_in  = 1'b1;
               bit_index_in = '0;
               shift_in     = '0;
               sign_in      = 1'b0;
               saw_high_in  = 1'b0;
            end
         end
         low_time_in = '0;
      end

      rsp.measured_value = stored_in;
      rsp.frame_done     = done;
      rsp.value_changed  = changed;
      rsp.gauge_attached = attached_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clk_ff  <= 1'b1;
         in_frame_ff  <= 1'b0;
         low_time_ff  <= '0;
         idle_time_ff <= '0;
         bit_index_ff <= '0;
         saw_high_ff  <= 1'b0;
         shift_ff     <= '0;
         sign_ff      <= 1'b0;
         stored_ff    <= '0;
         attached_ff  <= 1'b1;
      end else if (accept) begin
         prev_clk_ff  <= prev_clk_in;
         in_frame_ff  <= in_frame_in;
         low_time_ff  <= low_time_in;
         idle_time_ff <= idle_time_in;
         bit_index_ff <= bit_index_in;
         saw_high_ff  <= saw_high_in;
         shift_ff     <= shift_in;
         sign_ff      <= sign_in;
         stored_ff    <= stored_in;
         attached_ff  <= attached_in;
      end
   end

endmodule

### hw/rtl/caliper_frame_decoder.sv
// A result beat is registered and is valid in the cycle after its sample beat is accepted.
// Throughput: one sample beat per cycle; the result register frees in the cycle
// its beat is taken, so req_ready stays high while rsp_ready is high.
// Reset (synchronous, active high): decoder state and config registers return
// to their defaults, the result register empties.
module caliper_frame_decoder
   import cfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   assign req_ready    = ~rsp_valid_ff | rsp_ready;
   assign accept       = req_valid & req_ready;
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   cfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cfd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp    (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

endmodule
